[design/rvicd_pkg.sv]
// package: opcodes, instruction ids, decode tables and control line sets
`timescale 1ns / 1ps
package rvicd_pkg;

	localparam int INSTR_W = 32;
	localparam int ID_W    = 6;
	localparam int REG_W   = 5;
	localparam int IMM_W   = 12;
	localparam int CTL_W   = 14;

	typedef logic [ID_W-1:0]  id_t;
	typedef logic [CTL_W-1:0] ctl_t;
	typedef logic [6:0]       opc_t;
	typedef logic [6:0]       f7_t;
	typedef logic [5:0]       f6_t;

	// major opcodes
	localparam opc_t OPC_OP      = 7'd51;
	localparam opc_t OPC_OP32    = 7'd59;
	localparam opc_t OPC_OPIMM   = 7'd19;
	localparam opc_t OPC_OPIMM32 = 7'd27;
	localparam opc_t OPC_LOAD    = 7'd3;
	localparam opc_t OPC_STORE   = 7'd35;
	localparam opc_t OPC_BRANCH  = 7'd99;
	localparam opc_t OPC_JALR    = 7'd103;
	localparam opc_t OPC_JAL     = 7'd111;
	localparam opc_t OPC_LUI     = 7'd55;
	localparam opc_t OPC_AUIPC   = 7'd23;
	localparam opc_t OPC_FP      = 7'd83;
	localparam opc_t OPC_FSTORE  = 7'd39;
	localparam opc_t OPC_FLOAD   = 7'd7;

	localparam f7_t F7_BASE   = 7'b0000000;
	localparam f7_t F7_ALT    = 7'b0100000;
	localparam f7_t F7_MULDIV = 7'b0000001;
	localparam f7_t F7_FSUB   = 7'b0000100;
	localparam f6_t F6_BASE   = 6'b000000;
	localparam f6_t F6_ALT    = 6'b010000;

	localparam logic [2:0] F3_ADD   = 3'd0;
	localparam logic [2:0] F3_SLL   = 3'd1;
	localparam logic [2:0] F3_WORD  = 3'd2;
	localparam logic [2:0] F3_SHR   = 3'd5;

	// instruction ids
	localparam id_t ID_NONE   = 6'd0;
	localparam id_t ID_ADD    = 6'd1;
	localparam id_t ID_SUB    = 6'd2;
	localparam id_t ID_SLL    = 6'd3;
	localparam id_t ID_SLT    = 6'd4;
	localparam id_t ID_SLTU   = 6'd5;
	localparam id_t ID_XOR    = 6'd6;
	localparam id_t ID_SRL    = 6'd7;
	localparam id_t ID_SRA    = 6'd8;
	localparam id_t ID_OR     = 6'd9;
	localparam id_t ID_AND    = 6'd10;
	localparam id_t ID_MUL    = 6'd11;
	localparam id_t ID_MULH   = 6'd12;
	localparam id_t ID_MULHSU = 6'd13;
	localparam id_t ID_MULHU  = 6'd14;
	localparam id_t ID_DIV    = 6'd15;
	localparam id_t ID_DIVU   = 6'd16;
	localparam id_t ID_REM    = 6'd17;
	localparam id_t ID_REMU   = 6'd18;
	localparam id_t ID_ADDW   = 6'd19;
	localparam id_t ID_SUBW   = 6'd20;
	localparam id_t ID_SLLW   = 6'd21;
	localparam id_t ID_SRLW   = 6'd22;
	localparam id_t ID_SRAW   = 6'd23;
	localparam id_t ID_MULW   = 6'd24;
	localparam id_t ID_DIVW   = 6'd25;
	localparam id_t ID_DIVUW  = 6'd26;
	localparam id_t ID_REMW   = 6'd27;
	localparam id_t ID_REMUW  = 6'd28;
	localparam id_t ID_ADDI   = 6'd29;
	localparam id_t ID_SLTI   = 6'd30;
	localparam id_t ID_SLTIU  = 6'd31;
	localparam id_t ID_XORI   = 6'd32;
	localparam id_t ID_ORI    = 6'd33;
	localparam id_t ID_ANDI   = 6'd34;
	localparam id_t ID_SLLI   = 6'd35;
	localparam id_t ID_SRLI   = 6'd36;
	localparam id_t ID_SRAI   = 6'd37;
	localparam id_t ID_ADDIW  = 6'd38;
	localparam id_t ID_SLLIW  = 6'd39;
	localparam id_t ID_SRLIW  = 6'd40;
	localparam id_t ID_SRAIW  = 6'd41;
	localparam id_t ID_LB     = 6'd42;
	localparam id_t ID_LH     = 6'd43;
	localparam id_t ID_LW     = 6'd44;
	localparam id_t ID_LBU    = 6'd45;
	localparam id_t ID_LHU    = 6'd46;
	localparam id_t ID_SB     = 6'd47;
	localparam id_t ID_SH     = 6'd48;
	localparam id_t ID_SW     = 6'd49;
	localparam id_t ID_BEQ    = 6'd50;
	localparam id_t ID_BNE    = 6'd51;
	localparam id_t ID_BLT    = 6'd52;
	localparam id_t ID_BGE    = 6'd53;
	localparam id_t ID_BLTU   = 6'd54;
	localparam id_t ID_BGEU   = 6'd55;
	localparam id_t ID_JALR   = 6'd56;
	localparam id_t ID_JAL    = 6'd57;
	localparam id_t ID_LUI    = 6'd58;
	localparam id_t ID_AUIPC  = 6'd59;
	localparam id_t ID_FADD   = 6'd60;
	localparam id_t ID_FSUB   = 6'd61;
	localparam id_t ID_FSW    = 6'd62;
	localparam id_t ID_FLW    = 6'd63;

	// tables indexed by funct3
	localparam id_t OP_BASE_TBL [0:7] = '{ID_ADD, ID_SLL, ID_SLT, ID_SLTU,
		ID_XOR, ID_SRL, ID_OR, ID_AND};
	localparam id_t OP_MUL_TBL [0:7] = '{ID_MUL, ID_MULH, ID_MULHSU, ID_MULHU,
		ID_DIV, ID_DIVU, ID_REM, ID_REMU};
	localparam id_t OPIMM_TBL [0:7] = '{ID_ADDI, ID_SLLI, ID_SLTI, ID_SLTIU,
		ID_XORI, ID_SRLI, ID_ORI, ID_ANDI};
	localparam id_t LOAD_TBL [0:7] = '{ID_LB, ID_LH, ID_LW, ID_NONE,
		ID_LBU, ID_LHU, ID_NONE, ID_NONE};
	localparam id_t STORE_TBL [0:7] = '{ID_SB, ID_SH, ID_SW, ID_NONE,
		ID_NONE, ID_NONE, ID_NONE, ID_NONE};
	localparam id_t BRANCH_TBL [0:7] = '{ID_BEQ, ID_BNE, ID_NONE, ID_NONE,
		ID_BLT, ID_BGE, ID_BLTU, ID_BGEU};

	// control line sets per class
	localparam ctl_t CTL_NONE   = 14'h0000;
	localparam ctl_t CTL_RTYPE  = 14'h0007;
	localparam ctl_t CTL_ITYPE  = 14'h000F;
	localparam ctl_t CTL_LOAD   = 14'h004F;
	localparam ctl_t CTL_STORE  = 14'h0089;
	localparam ctl_t CTL_BRANCH = 14'h0021;
	localparam ctl_t CTL_JALR   = 14'h001D;
	localparam ctl_t CTL_JAL    = 14'h001C;
	localparam ctl_t CTL_LUI    = 14'h0006;
	localparam ctl_t CTL_AUIPC  = 14'h000F;
	localparam ctl_t CTL_FADD   = 14'h0200;
	localparam ctl_t CTL_FSUB   = 14'h0400;
	localparam ctl_t CTL_FSW    = 14'h2008;
	localparam ctl_t CTL_FLW    = 14'h1048;

endpackage

[design/riscv_instruction_control_decoder.sv]
// top level: registered instruction decoder, id, illegal flag, registers, immediate, controls
//
// Takes one instruction request per cycle: busy is always low, so start may be high in
// every cycle. Each request is captured in an input register and decoded by one pass of
// combinational logic into a result register; its result appears at the next edge after
// the accepting one, for one cycle, with done high, and is taken at the edge that ends
// that done cycle. Results come out in request order and the receiver cannot stall
// them, so it must take every done cycle.
`timescale 1ns / 1ps
module riscv_instruction_control_decoder (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic [rvicd_pkg::INSTR_W-1:0]        instruction_word,
	output logic                                 done,
	output logic [rvicd_pkg::ID_W-1:0]           op_id,
	output logic                                 illegal,
	output logic [rvicd_pkg::REG_W-1:0]          dest_reg,
	output logic [rvicd_pkg::REG_W-1:0]          src1_reg,
	output logic [rvicd_pkg::REG_W-1:0]          src2_reg,
	output logic signed [rvicd_pkg::IMM_W-1:0]   immediate,
	output logic [rvicd_pkg::CTL_W-1:0]          control_lines
);
	import rvicd_pkg::*;

	logic               valid_s1;
	logic [INSTR_W-1:0] instr_s1;
	logic               valid_s2;
	id_t                id_s2;
	logic [24:7]        instr_s2;
	logic [IMM_W-1:0]   imm_s2;
	ctl_t               ctl_s2;

	opc_t               opc;
	logic [2:0]         f3;
	f7_t                f7;
	f6_t                f6;
	id_t                id_d;
	logic [IMM_W-1:0]   imm_i;
	logic [IMM_W-1:0]   imm_st;
	logic [IMM_W-1:0]   imm_d;
	ctl_t               ctl_d;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= start;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			instr_s1 <= instruction_word;
		end
		if (valid_s1) begin
			instr_s2 <= instr_s1[24:7];
			id_s2    <= id_d;
			imm_s2   <= imm_d;
			ctl_s2   <= ctl_d;
		end
	end

	assign opc    = instr_s1[6:0];
	assign f3     = instr_s1[14:12];
	assign f7     = instr_s1[31:25];
	assign f6     = instr_s1[31:26];
	assign imm_i  = instr_s1[31:20];
	assign imm_st = {instr_s1[31:25], instr_s1[11:7]};

	// instruction id
	always_comb begin
		id_d = ID_NONE;
		case (opc)
			OPC_OP: begin
				if (f7 == F7_BASE) id_d = OP_BASE_TBL[f3];
				else if (f7 == F7_MULDIV) id_d = OP_MUL_TBL[f3];
				else if (f7 == F7_ALT && f3 == F3_ADD) id_d = ID_SUB;
				else if (f7 == F7_ALT && f3 == F3_SHR) id_d = ID_SRA;
			end
			OPC_OP32: begin
				if (f7 == F7_BASE) begin
					if (f3 == F3_ADD) id_d = ID_ADDW;
					else if (f3 == F3_SLL) id_d = ID_SLLW;
					else if (f3 == F3_SHR) id_d = ID_SRLW;
				end else if (f7 == F7_ALT) begin
					if (f3 == F3_ADD) id_d = ID_SUBW;
					else if (f3 == F3_SHR) id_d = ID_SRAW;
				end else if (f7 == F7_MULDIV) begin
					if (f3 == F3_ADD) id_d = ID_MULW;
					else if (f3[2]) id_d = ID_DIVW + {4'd0, f3[1:0]};
				end
			end
			OPC_OPIMM: begin
				if (f3 == F3_SLL) begin
					if (f6 == F6_BASE) id_d = ID_SLLI;
				end else if (f3 == F3_SHR) begin
					if (f6 == F6_BASE) id_d = ID_SRLI;
					else if (f6 == F6_ALT) id_d = ID_SRAI;
				end else begin
					id_d = OPIMM_TBL[f3];
				end
			end
			OPC_OPIMM32: begin
				if (f3 == F3_ADD) id_d = ID_ADDIW;
				else if (f3 == F3_SLL) begin
					if (f7 == F7_BASE) id_d = ID_SLLIW;
				end else if (f3 == F3_SHR) begin
					if (f7 == F7_BASE) id_d = ID_SRLIW;
					else if (f7 == F7_ALT) id_d = ID_SRAIW;
				end
			end
			OPC_LOAD:   id_d = LOAD_TBL[f3];
			OPC_STORE:  id_d = STORE_TBL[f3];
			OPC_BRANCH: id_d = BRANCH_TBL[f3];
			OPC_JALR:   id_d = (f3 == F3_ADD) ? ID_JALR : ID_NONE;
			OPC_JAL:    id_d = ID_JAL;
			OPC_LUI:    id_d = ID_LUI;
			OPC_AUIPC:  id_d = ID_AUIPC;
			OPC_FP: begin
				if (f7 == F7_BASE) id_d = ID_FADD;
				else if (f7 == F7_FSUB) id_d = ID_FSUB;
			end
			OPC_FSTORE: id_d = (f3 == F3_WORD) ? ID_FSW : ID_NONE;
			OPC_FLOAD:  id_d = (f3 == F3_WORD) ? ID_FLW : ID_NONE;
			default:    id_d = ID_NONE;
		endcase
	end

	// control lines and immediate by class
	always_comb begin
		ctl_d = CTL_NONE;
		imm_d = '0;
		if (id_d >= ID_ADD && id_d <= ID_REMUW) begin
			ctl_d = CTL_RTYPE;
		end else if (id_d >= ID_ADDI && id_d <= ID_SRAIW) begin
			ctl_d = CTL_ITYPE;
			imm_d = imm_i;
		end else if (id_d >= ID_LB && id_d <= ID_LHU) begin
			ctl_d = CTL_LOAD;
			imm_d = imm_i;
		end else if (id_d >= ID_SB && id_d <= ID_SW) begin
			ctl_d = CTL_STORE;
			imm_d = imm_st;
		end else if (id_d >= ID_BEQ && id_d <= ID_BGEU) begin
			ctl_d = CTL_BRANCH;
		end else if (id_d == ID_JALR) begin
			ctl_d = CTL_JALR;
			imm_d = imm_i;
		end else if (id_d == ID_JAL) begin
			ctl_d = CTL_JAL;
		end else if (id_d == ID_LUI) begin
			ctl_d = CTL_LUI;
		end else if (id_d == ID_AUIPC) begin
			ctl_d = CTL_AUIPC;
		end else if (id_d == ID_FADD) begin
			ctl_d = CTL_FADD;
		end else if (id_d == ID_FSUB) begin
			ctl_d = CTL_FSUB;
		end else if (id_d == ID_FSW) begin
			ctl_d = CTL_FSW;
			imm_d = imm_st;
		end else if (id_d == ID_FLW) begin
			ctl_d = CTL_FLW;
			imm_d = imm_i;
		end
	end

	assign done          = valid_s2;
	assign op_id         = id_s2;
	assign illegal       = (id_s2 == ID_NONE);
	assign dest_reg      = instr_s2[11:7];
	assign src1_reg      = instr_s2[19:15];
	assign src2_reg      = instr_s2[24:20];
	assign immediate     = signed'(imm_s2);
	assign control_lines = ctl_s2;

endmodule

[verif/riscv_instruction_control_decoder_test.sv]
// testbench: random and directed instruction requests checked against a decode predictor
`timescale 1ns / 1ps
module riscv_instruction_control_decoder_test;
	import rvicd_pkg::*;

	localparam int   STALL_LIMIT  = 1000;
	localparam int   PHASE_ITEMS  = 134;
	localparam int   NUM_CLASSES  = 14;

	localparam opc_t CLASS_OPC [NUM_CLASSES] = '{OPC_OP, OPC_OP32, OPC_OPIMM, OPC_OPIMM32,
		OPC_LOAD, OPC_STORE, OPC_BRANCH, OPC_JALR, OPC_JAL, OPC_LUI, OPC_AUIPC, OPC_FP,
		OPC_FSTORE, OPC_FLOAD};

	// ids by funct3
	localparam id_t ALU_IDS [8] = '{ID_ADD, ID_SLL, ID_SLT, ID_SLTU, ID_XOR, ID_SRL,
		ID_OR, ID_AND};
	localparam id_t MULDIV_IDS [8] = '{ID_MUL, ID_MULH, ID_MULHSU, ID_MULHU, ID_DIV,
		ID_DIVU, ID_REM, ID_REMU};
	localparam id_t WORD_IDS [8] = '{ID_ADDW, ID_SLLW, ID_NONE, ID_NONE, ID_NONE,
		ID_SRLW, ID_NONE, ID_NONE};
	localparam id_t WORD_ALT_IDS [8] = '{ID_SUBW, ID_NONE, ID_NONE, ID_NONE, ID_NONE,
		ID_SRAW, ID_NONE, ID_NONE};
	localparam id_t WORD_MULDIV_IDS [8] = '{ID_MULW, ID_NONE, ID_NONE, ID_NONE, ID_DIVW,
		ID_DIVUW, ID_REMW, ID_REMUW};
	localparam id_t ALUI_IDS [8] = '{ID_ADDI, ID_NONE, ID_SLTI, ID_SLTIU, ID_XORI,
		ID_NONE, ID_ORI, ID_ANDI};
	localparam id_t LOAD_IDS [8] = '{ID_LB, ID_LH, ID_LW, ID_NONE, ID_LBU, ID_LHU,
		ID_NONE, ID_NONE};
	localparam id_t STORE_IDS [8] = '{ID_SB, ID_SH, ID_SW, ID_NONE, ID_NONE, ID_NONE,
		ID_NONE, ID_NONE};
	localparam id_t BRANCH_IDS [8] = '{ID_BEQ, ID_BNE, ID_NONE, ID_NONE, ID_BLT, ID_BGE,
		ID_BLTU, ID_BGEU};

	typedef struct {
		id_t                      op_id;
		logic                     illegal;
		logic [REG_W-1:0]         rd;
		logic [REG_W-1:0]         rs1;
		logic [REG_W-1:0]         rs2;
		logic signed [IMM_W-1:0]  imm;
		ctl_t                     ctl;
	} decode_fields_t;

	class decode_checker;
		decode_fields_t expected_decodes[$];
		int mismatches;

		function new();
			mismatches = 0;
		endfunction

		function automatic id_t decode_id(logic [INSTR_W-1:0] w);
			opc_t       opc;
			logic [2:0] f3;
			f7_t        f7;
			f6_t        f6;
			opc = w[6:0];
			f3  = w[14:12];
			f7  = w[31:25];
			f6  = w[31:26];
			case (opc)
				OPC_OP: begin
					if (f7 == F7_BASE) return ALU_IDS[f3];
					if (f7 == F7_MULDIV) return MULDIV_IDS[f3];
					if (f7 == F7_ALT && f3 == F3_ADD) return ID_SUB;
					if (f7 == F7_ALT && f3 == F3_SHR) return ID_SRA;
					return ID_NONE;
				end
				OPC_OP32: begin
					if (f7 == F7_BASE) return WORD_IDS[f3];
					if (f7 == F7_ALT) return WORD_ALT_IDS[f3];
					if (f7 == F7_MULDIV) return WORD_MULDIV_IDS[f3];
					return ID_NONE;
				end
				OPC_OPIMM: begin
					// rv64 shift amount is six bits, so only bits 31..26 are tested
					if (f3 == F3_SLL) return f6 == F6_BASE ? ID_SLLI : ID_NONE;
					if (f3 == F3_SHR) begin
						if (f6 == F6_BASE) return ID_SRLI;
						if (f6 == F6_ALT) return ID_SRAI;
						return ID_NONE;
					end
					return ALUI_IDS[f3];
				end
				OPC_OPIMM32: begin
					if (f3 == F3_ADD) return ID_ADDIW;
					if (f3 == F3_SLL) return f7 == F7_BASE ? ID_SLLIW : ID_NONE;
					if (f3 == F3_SHR) begin
						if (f7 == F7_BASE) return ID_SRLIW;
						if (f7 == F7_ALT) return ID_SRAIW;
					end
					return ID_NONE;
				end
				OPC_LOAD:   return LOAD_IDS[f3];
				OPC_STORE:  return STORE_IDS[f3];
				OPC_BRANCH: return BRANCH_IDS[f3];
				OPC_JALR:   return f3 == F3_ADD ? ID_JALR : ID_NONE;
				OPC_JAL:    return ID_JAL;
				OPC_LUI:    return ID_LUI;
				OPC_AUIPC:  return ID_AUIPC;
				OPC_FP: begin
					// rounding mode ignored
					if (f7 == F7_BASE) return ID_FADD;
					if (f7 == F7_FSUB) return ID_FSUB;
					return ID_NONE;
				end
				OPC_FSTORE: return f3 == F3_WORD ? ID_FSW : ID_NONE;
				OPC_FLOAD:  return f3 == F3_WORD ? ID_FLW : ID_NONE;
				default:    return ID_NONE;
			endcase
		endfunction

		function automatic decode_fields_t predict_decode(logic [INSTR_W-1:0] w);
			decode_fields_t    d;
			logic [IMM_W-1:0]  imm_i;
			logic [IMM_W-1:0]  imm_s;
			imm_i     = w[31:20];
			imm_s     = {w[31:25], w[11:7]};
			d.op_id   = decode_id(w);
			d.illegal = d.op_id == ID_NONE;
			d.rd      = w[11:7];
			d.rs1     = w[19:15];
			d.rs2     = w[24:20];
			d.imm     = '0;
			d.ctl     = CTL_NONE;
			if (d.op_id >= ID_ADD && d.op_id <= ID_REMUW) begin
				d.ctl = CTL_RTYPE;
			end else if (d.op_id >= ID_ADDI && d.op_id <= ID_SRAIW) begin
				d.ctl = CTL_ITYPE;
				d.imm = imm_i;
			end else if (d.op_id >= ID_LB && d.op_id <= ID_LHU) begin
				d.ctl = CTL_LOAD;
				d.imm = imm_i;
			end else if (d.op_id >= ID_SB && d.op_id <= ID_SW) begin
				d.ctl = CTL_STORE;
				d.imm = imm_s;
			end else if (d.op_id >= ID_BEQ && d.op_id <= ID_BGEU) begin
				d.ctl = CTL_BRANCH;
			end else begin
				case (d.op_id)
					ID_JALR: begin
						d.ctl = CTL_JALR;
						d.imm = imm_i;
					end
					ID_JAL:   d.ctl = CTL_JAL;
					ID_LUI:   d.ctl = CTL_LUI;
					ID_AUIPC: d.ctl = CTL_AUIPC;
					ID_FADD:  d.ctl = CTL_FADD;
					ID_FSUB:  d.ctl = CTL_FSUB;
					ID_FSW: begin
						d.ctl = CTL_FSW;
						d.imm = imm_s;
					end
					ID_FLW: begin
						d.ctl = CTL_FLW;
						d.imm = imm_i;
					end
					default: d.ctl = CTL_NONE;
				endcase
			end
			return d;
		endfunction

		function void note_request(logic [INSTR_W-1:0] w);
			expected_decodes.push_back(predict_decode(w));
		endfunction

		function void check_result(decode_fields_t got);
			decode_fields_t exp;
			if (expected_decodes.size() == 0) begin
				$display("%0t: result with no request outstanding, op_id %0d", $time,
					got.op_id);
				mismatches++;
				return;
			end
			exp = expected_decodes.pop_front();
			if (got.op_id !== exp.op_id) begin
				$display("%0t: op_id expected %0d actual %0d", $time, exp.op_id, got.op_id);
				mismatches++;
			end
			if (got.illegal !== exp.illegal) begin
				$display("%0t: illegal expected %0b actual %0b", $time, exp.illegal,
					got.illegal);
				mismatches++;
			end
			if (got.rd !== exp.rd) begin
				$display("%0t: dest_reg expected %0d actual %0d", $time, exp.rd, got.rd);
				mismatches++;
			end
			if (got.rs1 !== exp.rs1) begin
				$display("%0t: src1_reg expected %0d actual %0d", $time, exp.rs1, got.rs1);
				mismatches++;
			end
			if (got.rs2 !== exp.rs2) begin
				$display("%0t: src2_reg expected %0d actual %0d", $time, exp.rs2, got.rs2);
				mismatches++;
			end
			if (got.imm !== exp.imm) begin
				$display("%0t: immediate expected %0d actual %0d", $time, exp.imm, got.imm);
				mismatches++;
			end
			if (got.ctl !== exp.ctl) begin
				$display("%0t: control_lines expected %h actual %h", $time, exp.ctl,
					got.ctl);
				mismatches++;
			end
		endfunction
	endclass

	logic                    clk;
	logic                    arst_n;
	logic                    start;
	logic                    busy;
	logic [INSTR_W-1:0]      instruction_word;
	logic                    done;
	logic [ID_W-1:0]         op_id;
	logic                    illegal;
	logic [REG_W-1:0]        dest_reg;
	logic [REG_W-1:0]        src1_reg;
	logic [REG_W-1:0]        src2_reg;
	logic signed [IMM_W-1:0] immediate;
	logic [CTL_W-1:0]        control_lines;

	decode_checker chk;
	int            quiet_cycles = 0;
	int            walk_index;

	riscv_instruction_control_decoder i_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.busy             (busy),
		.instruction_word (instruction_word),
		.done             (done),
		.op_id            (op_id),
		.illegal          (illegal),
		.dest_reg         (dest_reg),
		.src1_reg         (src1_reg),
		.src2_reg         (src2_reg),
		.immediate        (immediate),
		.control_lines    (control_lines)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// request and result monitor, plus watchdog
	always @(posedge clk) begin
		decode_fields_t got;
		if (arst_n) begin
			if (done) begin
				got.op_id   = op_id;
				got.illegal = illegal;
				got.rd      = dest_reg;
				got.rs1     = src1_reg;
				got.rs2     = src2_reg;
				got.imm     = immediate;
				got.ctl     = control_lines;
				chk.check_result(got);
			end
			if (start && !busy) chk.note_request(instruction_word);
		end
		if ((start && !busy) || done) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("FAIL riscv_instruction_control_decoder");
			$finish;
		end
	end

	function automatic logic [INSTR_W-1:0] pack_word(f7_t f7, logic [4:0] rs2,
		logic [4:0] rs1, logic [2:0] f3, logic [4:0] rd, opc_t opc);
		return {f7, rs2, rs1, f3, rd, opc};
	endfunction

	task automatic send_request(logic [INSTR_W-1:0] w, int idle_pct);
		while ($urandom_range(99) < idle_pct) begin
			start            <= 1'b0;
			instruction_word <= $urandom;
			@(posedge clk);
		end
		start            <= 1'b1;
		instruction_word <= w;
		do @(posedge clk); while (busy);
	endtask

	// walks opcode class, funct3 and funct7 choice in turn with random remaining bits
	function automatic logic [INSTR_W-1:0] walk_word(int k);
		logic [INSTR_W-1:0] w;
		opc_t               opc;
		int                 choice;
		opc    = CLASS_OPC[k % NUM_CLASSES];
		choice = (k / (NUM_CLASSES * 8)) % 3;
		w      = $urandom;
		w[6:0]   = opc;
		w[14:12] = 3'((k / NUM_CLASSES) % 8);
		if (choice == 0) begin
			w[31:25] = F7_BASE;
		end else if (choice == 1) begin
			w[31:25] = opc == OPC_FP ? F7_FSUB : F7_ALT;
		end else if (opc == OPC_OP || opc == OPC_OP32) begin
			w[31:25] = F7_MULDIV;
		end
		if (opc == OPC_OPIMM && choice != 2) w[25] = 1'($urandom_range(1));
		return w;
	endfunction

	task automatic run_random_phase(int items, int idle_pct);
		logic [INSTR_W-1:0] w;
		for (int i = 0; i < items; i++) begin
			if ($urandom_range(99) < 80) begin
				w = walk_word(walk_index);
				walk_index++;
			end else if ($urandom_range(1) == 1) begin
				w = $urandom;
			end else begin
				w = $urandom;
				w[6:0] = CLASS_OPC[$urandom_range(NUM_CLASSES - 1)];
			end
			send_request(w, idle_pct);
		end
	endtask

	initial begin
		logic [INSTR_W-1:0] directed[$];
		chk              = new();
		walk_index       = $urandom_range(1000);
		arst_n           = 1'b0;
		start            = 1'b0;
		instruction_word = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed = '{
			32'h0000_0000,
			32'hFFFF_FFFF,
			// immediate extremes
			pack_word(7'h40, 5'd0, 5'd31, F3_ADD, 5'd31, OPC_OPIMM),
			pack_word(7'h3F, 5'd31, 5'd0, F3_ADD, 5'd0, OPC_OPIMM),
			pack_word(7'h40, 5'd31, 5'd31, F3_WORD, 5'd0, OPC_STORE),
			pack_word(7'h3F, 5'd0, 5'd0, F3_ADD, 5'd31, OPC_STORE),
			pack_word(7'h7F, 5'd31, 5'd1, F3_WORD, 5'd31, OPC_FSTORE),
			pack_word(7'h40, 5'd3, 5'd2, F3_WORD, 5'd4, OPC_FLOAD),
			// six-bit shift amounts
			pack_word(F7_ALT | 7'h01, 5'd31, 5'd5, F3_SHR, 5'd6, OPC_OPIMM),
			pack_word(F7_BASE | 7'h01, 5'd7, 5'd5, F3_SLL, 5'd6, OPC_OPIMM),
			pack_word(7'h02, 5'd7, 5'd5, F3_SLL, 5'd6, OPC_OPIMM),
			pack_word(F7_ALT | 7'h01, 5'd7, 5'd5, F3_SHR, 5'd6, OPC_OPIMM32),
			pack_word(F7_ALT, 5'd31, 5'd5, F3_SHR, 5'd6, OPC_OPIMM32),
			pack_word(F7_BASE | 7'h01, 5'd7, 5'd5, F3_SLL, 5'd6, OPC_OPIMM32),
			// rounding mode ignored, bad funct7
			pack_word(F7_BASE, 5'd1, 5'd2, 3'b111, 5'd3, OPC_FP),
			pack_word(F7_FSUB, 5'd1, 5'd2, 3'b011, 5'd3, OPC_FP),
			pack_word(F7_ALT, 5'd1, 5'd2, F3_ADD, 5'd3, OPC_FP),
			// upper immediates and jal with nonzero funct3
			pack_word(7'h55, 5'd10, 5'd11, 3'b111, 5'd12, OPC_LUI),
			pack_word(7'h2A, 5'd10, 5'd11, 3'b011, 5'd12, OPC_AUIPC),
			pack_word(7'h7F, 5'd31, 5'd31, 3'b111, 5'd31, OPC_JAL),
			// funct3 or funct7 holes
			pack_word(F7_BASE, 5'd1, 5'd1, F3_SLL, 5'd1, OPC_JALR),
			pack_word(F7_ALT, 5'd1, 5'd1, F3_SLL, 5'd1, OPC_OP),
			pack_word(F7_MULDIV, 5'd1, 5'd1, F3_WORD, 5'd1, OPC_OP32),
			pack_word(F7_BASE, 5'd1, 5'd1, F3_WORD, 5'd1, OPC_BRANCH),
			pack_word(F7_BASE, 5'd1, 5'd1, 3'b011, 5'd1, OPC_LOAD)
		};
		foreach (directed[i]) send_request(directed[i], 0);

		run_random_phase(PHASE_ITEMS, 0);
		run_random_phase(PHASE_ITEMS, 87);
		run_random_phase(PHASE_ITEMS, 33);
		start <= 1'b0;

		while (chk.expected_decodes.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		if (chk.mismatches == 0 && chk.expected_decodes.size() == 0) begin
			$display("PASS riscv_instruction_control_decoder");
		end else begin
			$display("FAIL riscv_instruction_control_decoder");
		end
		$finish;
	end

endmodule

[sim.f]
design/rvicd_pkg.sv
design/riscv_instruction_control_decoder.sv
verif/riscv_instruction_control_decoder_test.sv
